// ----- design/gtdc_pkg.sv -----
package gtdc_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEEP_MODE     = 2'd2;

	// Decimation is used above these frame sizes
	localparam logic [11:0] SCALE_MIN_W = 12'd400;
	localparam logic [11:0] SCALE_MIN_H = 12'd300;

	// floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for any 12-bit x
	localparam logic [11:0] DIV3_MUL   = 12'd2731;
	localparam int          DIV3_SHIFT = 13;

	// Reset values of the registers
	localparam logic [11:0] RST_DIM  = 12'd128;
	localparam logic        RST_DEEP = 1'b1;

	// Texel format constants
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [31:0] texel;
		logic [11:0] col;
		logic [11:0] row;
		logic        row_end;
		logic        frame_end;
	} texel_req_t;

endpackage

// ----- design/gray_texel_decimating_converter.sv -----
// A kept pixel goes to the output register, or to the skid if that is stalled.
// Throughput: one pixel per clock while in_stall is low; the output register plus
// a one-entry skid stage let a pixel be taken while a finished texel is stalled.
// Reset: asynchronous, active low; clears position counters and handshake state,
// width and height return to 128, deep mode to 1.
module gray_texel_decimating_converter #(
	parameter int MAX_DIM = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	// pixel request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel_value,
	// texel request channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] texel,
	output logic [11:0] texel_col,
	output logic [11:0] texel_row,
	output logic        row_end,
	output logic        frame_end
);

	// zero acts as one, large sizes saturate at MAX_DIM
	function automatic logic [11:0] clamp_dim(input logic [11:0] v);
		logic [11:0] r;
		r = v;
		if (v == 12'd0)
			r = 12'd1;
		else if ({4'd0, v} > 16'(MAX_DIM))
			r = 12'(MAX_DIM);
		return r;
	endfunction

	function automatic logic [11:0] div3(input logic [11:0] v);
		logic [24:0] p;
		p = {13'd0, v} * {13'd0, gtdc_pkg::DIV3_MUL};
		return p[gtdc_pkg::DIV3_SHIFT +: 12];
	endfunction

	function automatic logic [1:0] next_phase(input logic [1:0] p, input logic sc);
		logic [1:0] r;
		r = 2'd0;
		if (sc && p < 2'd2)
			r = p + 2'd1;
		return r;
	endfunction

	// configuration, stored already clamped and divided
	logic [11:0] w_q, h_q, w3_q, h3_q;
	logic        deep_q;
	logic [11:0] cfg_clamped;

	assign cfg_clamped = clamp_dim(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= gtdc_pkg::RST_DIM;
			h_q    <= gtdc_pkg::RST_DIM;
			w3_q   <= div3(gtdc_pkg::RST_DIM);
			h3_q   <= div3(gtdc_pkg::RST_DIM);
			deep_q <= gtdc_pkg::RST_DEEP;
		end else if (cfg_write) begin
			case (cfg_index)
				gtdc_pkg::REG_SOURCE_WIDTH: begin
					w_q  <= cfg_clamped;
					w3_q <= div3(cfg_clamped);
				end
				gtdc_pkg::REG_SOURCE_HEIGHT: begin
					h_q  <= cfg_clamped;
					h3_q <= div3(cfg_clamped);
				end
				gtdc_pkg::REG_DEEP_MODE: deep_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// position state
	logic [11:0] src_col_q, src_row_q, out_col_q, out_row_q;
	logic [1:0]  col_ph_q, row_ph_q;

	// skid stage
	logic                 skid_valid_q;
	gtdc_pkg::texel_req_t skid_q;
	gtdc_pkg::texel_req_t out_q;
	logic                 out_valid_q;

	// per-pixel decode
	logic                 scaled, row_kept, emit, accept, col_wrap, row_wrap;
	logic [11:0]          tw, th;
	gtdc_pkg::texel_req_t res;

	assign accept   = in_valid && !skid_valid_q;
	assign scaled   = (w_q > gtdc_pkg::SCALE_MIN_W) && (h_q > gtdc_pkg::SCALE_MIN_H);
	assign tw       = scaled ? w3_q : w_q;
	assign th       = scaled ? h3_q : h_q;
	assign row_kept = (row_ph_q == 2'd0) && (out_row_q < th);
	assign emit     = row_kept && (col_ph_q == 2'd0) && (out_col_q < tw);
	assign col_wrap = src_col_q >= (w_q - 12'd1);
	assign row_wrap = src_row_q >= (h_q - 12'd1);

	// texel formatting
	always_comb begin
		if (deep_q)
			res.texel = {gtdc_pkg::ALPHA_OPAQUE, pixel_value, pixel_value, pixel_value};
		else
			res.texel = {16'd0, 1'b1, pixel_value[7:3], pixel_value[7:3], pixel_value[7:3]};
		res.col       = out_col_q;
		res.row       = out_row_q;
		res.row_end   = (out_col_q == tw - 12'd1);
		res.frame_end = res.row_end && (out_row_q == th - 12'd1);
	end

	// counter update per accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			col_ph_q  <= '0;
			row_ph_q  <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				src_col_q <= '0;
				col_ph_q  <= '0;
				out_col_q <= '0;
				if (row_wrap) begin
					src_row_q <= '0;
					row_ph_q  <= '0;
					out_row_q <= '0;
				end else begin
					src_row_q <= src_row_q + 12'd1;
					if (row_kept)
						out_row_q <= out_row_q + 12'd1;
					row_ph_q <= next_phase(row_ph_q, scaled);
				end
			end else begin
				src_col_q <= src_col_q + 12'd1;
				col_ph_q  <= next_phase(col_ph_q, scaled);
				if (emit)
					out_col_q <= out_col_q + 12'd1;
			end
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && emit;
			end
		end else if (accept && emit) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (accept && emit)
				out_q <= res;
		end else if (accept && emit) begin
			skid_q <= res;
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign texel     = out_q.texel;
	assign texel_col = out_q.col;
	assign texel_row = out_q.row;
	assign row_end   = out_q.row_end;
	assign frame_end = out_q.frame_end;

`ifndef SYNTH
	// skid only fills behind an occupied output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a texel while the output register is empty");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without an output stall");

	// end of frame is always an end of row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_end) |-> out_q.row_end)
		else $error("frame end without row end");
`endif

endmodule

// ----- dv/tb_gray_texel_decimating_converter.sv -----
module tb_gray_texel_decimating_converter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PIXELS = 430;

	// Clock, reset and block ports
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_write   = 1'b0;
	logic [1:0]  cfg_index   = gtdc_pkg::REG_SOURCE_WIDTH;
	logic [11:0] cfg_data    = '0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel_value = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [31:0] texel;
	logic [11:0] texel_col;
	logic [11:0] texel_row;
	logic        row_end;
	logic        frame_end;

	// Predictor copy of the registers and position counters
	logic [11:0] cfg_width  = gtdc_pkg::RST_DIM;
	logic [11:0] cfg_height = gtdc_pkg::RST_DIM;
	logic        cfg_deep   = gtdc_pkg::RST_DEEP;
	logic [11:0] src_col    = '0;
	logic [11:0] src_row    = '0;
	logic [1:0]  col_ph     = '0;
	logic [1:0]  row_ph     = '0;
	logic [11:0] tex_col    = '0;
	logic [11:0] tex_row    = '0;

	gtdc_pkg::texel_req_t texels_due[$];

	int  pixels_sent    = 0;
	int  texels_checked = 0;
	int  rows_closed    = 0;
	int  frames_closed  = 0;
	int  error_count    = 0;
	int  cycle_count    = 0;
	int  stall_left     = 0;
	bit  tx_idle        = 1'b1;
	bit  rx_idle        = 1'b1;

	gray_texel_decimating_converter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_value(pixel_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.texel      (texel),
		.texel_col  (texel_col),
		.texel_row  (texel_row),
		.row_end    (row_end),
		.frame_end  (frame_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycles to hold off before the next request or after a texel
	function automatic int draw_wait(input bit enabled);
		return enabled ? int'($urandom_range(0, 3)) : 0;
	endfunction

	// Works out the texel (if any) for one accepted pixel and steps the counters
	function automatic void predict_texel(input logic [7:0] level);
		logic [11:0] w, h, tw, th;
		logic        scaled, row_kept;
		logic [4:0]  g;
		gtdc_pkg::texel_req_t t;
		w        = (cfg_width == 12'd0) ? 12'd1 : cfg_width;
		h        = (cfg_height == 12'd0) ? 12'd1 : cfg_height;
		scaled   = (w > gtdc_pkg::SCALE_MIN_W) && (h > gtdc_pkg::SCALE_MIN_H);
		tw       = scaled ? w / 12'd3 : w;
		th       = scaled ? h / 12'd3 : h;
		row_kept = (row_ph == 2'd0) && (tex_row < th);
		g        = level[7:3];

		if (row_kept && col_ph == 2'd0 && tex_col < tw) begin
			t.texel     = cfg_deep ? {gtdc_pkg::ALPHA_OPAQUE, level, level, level}
			                       : {16'h0000, 1'b1, g, g, g};
			t.col       = tex_col;
			t.row       = tex_row;
			t.row_end   = (tex_col == tw - 12'd1);
			t.frame_end = t.row_end && (tex_row == th - 12'd1);
			texels_due.push_back(t);
			tex_col = tex_col + 12'd1;
		end

		// Row and frame wrap use >= so that a shrunk size resyncs
		if (src_col >= w - 12'd1) begin
			src_col = '0;
			col_ph  = '0;
			tex_col = '0;
			if (src_row >= h - 12'd1) begin
				src_row = '0;
				row_ph  = '0;
				tex_row = '0;
			end else begin
				src_row = src_row + 12'd1;
				if (row_kept)
					tex_row = tex_row + 12'd1;
				row_ph = (!scaled || row_ph >= 2'd2) ? 2'd0 : row_ph + 2'd1;
			end
		end else begin
			src_col = src_col + 12'd1;
			col_ph  = (!scaled || col_ph >= 2'd2) ? 2'd0 : col_ph + 2'd1;
		end
	endfunction

	function automatic void compare_field(input string field, input logic [31:0] exp_v,
	                                      input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
		end
	endfunction

	function automatic void check_texel();
		gtdc_pkg::texel_req_t exp_t;
		if (texels_due.size() == 0) begin
			error_count++;
			$display("%0t: unexpected texel, expected none, actual %h at col %0d row %0d",
			         $time, texel, texel_col, texel_row);
		end else begin
			exp_t = texels_due.pop_front();
			compare_field("texel", exp_t.texel, texel);
			compare_field("texel_col", 32'(exp_t.col), 32'(texel_col));
			compare_field("texel_row", 32'(exp_t.row), 32'(texel_row));
			compare_field("row_end", 32'(exp_t.row_end), 32'(row_end));
			compare_field("frame_end", 32'(exp_t.frame_end), 32'(frame_end));
		end
		texels_checked++;
		if (row_end === 1'b1)
			rows_closed++;
		if (frame_end === 1'b1)
			frames_closed++;
	endfunction

	// Texel receiver: checks each accepted request, then stalls at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && !out_stall) begin
				check_texel();
				stall_left = draw_wait(rx_idle);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d texels outstanding",
			         cycle_count, texels_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Sends one pixel request; returns at the edge where it is accepted
	task automatic send_pixel(input logic [7:0] level);
		int gap;
		gap = draw_wait(tx_idle);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= level;
		do @(posedge clk); while (in_stall);
		predict_texel(level);
		pixels_sent++;
	endtask

	// Sender holds off until every texel is back and the pipe has emptied
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (texels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			gtdc_pkg::REG_SOURCE_WIDTH:  cfg_width  = val;
			gtdc_pkg::REG_SOURCE_HEIGHT: cfg_height = val;
			gtdc_pkg::REG_DEEP_MODE:     cfg_deep   = val[0];
			default: ;
		endcase
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Two pixels straight out of reset: 128x128 frame, deep format
	task automatic test_reset_defaults();
		send_pixel(8'h00);
		send_pixel(8'hFF);
		wait_idle();
	endtask

	// Zero sizes act as a 1x1 frame: every pixel closes a row and a frame.
	// Both texel formats, with levels on the five-bit truncation edges.
	task automatic test_unit_frames();
		logic [7:0] deep_levels[6]    = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h08, 8'h07};
		logic [7:0] shallow_levels[6] = '{8'hFF, 8'h00, 8'hF8, 8'h07, 8'h55, 8'hAA};
		write_reg(gtdc_pkg::REG_SOURCE_WIDTH, 12'd0);
		write_reg(gtdc_pkg::REG_SOURCE_HEIGHT, 12'd0);
		foreach (deep_levels[i])
			send_pixel(deep_levels[i]);
		wait_idle();
		// only bit 0 of the mode data counts
		write_reg(gtdc_pkg::REG_DEEP_MODE, 12'hFFE);
		foreach (shallow_levels[i])
			send_pixel(shallow_levels[i]);
		wait_idle();
	endtask

	// Largest frame (decimated), then a shrink that leaves the counters mid-row
	task automatic test_extreme_size();
		write_reg(gtdc_pkg::REG_SOURCE_WIDTH, 12'hFFF);
		write_reg(gtdc_pkg::REG_SOURCE_HEIGHT, 12'hFFF);
		write_reg(gtdc_pkg::REG_DEEP_MODE, 12'h001);
		repeat (3) send_pixel(8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(gtdc_pkg::REG_SOURCE_WIDTH, 12'd3);
		write_reg(gtdc_pkg::REG_SOURCE_HEIGHT, 12'd2);
		repeat (6) send_pixel(8'($urandom_range(0, 255)));
		wait_idle();
	endtask

	// Walks the texel row up to 99 with a one-pixel-wide frame, then switches to
	// 401x301 so that a single decimated row ends the frame; the next row is a
	// skipped one, and a 1x1 frame resyncs the counters afterwards.
	task automatic test_scaled_frame_end();
		write_reg(gtdc_pkg::REG_SOURCE_WIDTH, 12'd1);
		write_reg(gtdc_pkg::REG_SOURCE_HEIGHT, 12'd4095);
		write_reg(gtdc_pkg::REG_DEEP_MODE, 12'($urandom_range(0, 1)));
		repeat (99) send_pixel(8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(gtdc_pkg::REG_SOURCE_WIDTH, 12'd401);
		write_reg(gtdc_pkg::REG_SOURCE_HEIGHT, 12'd301);
		repeat (802) send_pixel(8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(gtdc_pkg::REG_SOURCE_WIDTH, 12'd1);
		write_reg(gtdc_pkg::REG_SOURCE_HEIGHT, 12'd1);
		repeat (2) send_pixel(8'($urandom_range(0, 255)));
		wait_idle();
	endtask

	// Segments of random pixels, each after a random size and mode change
	task automatic test_random_frames(input int pixel_goal);
		int          first, shape, seg_len;
		logic [11:0] w, h;
		first = pixels_sent;
		while (pixels_sent - first < pixel_goal) begin
			wait_idle();
			shape = $urandom_range(0, 9);
			case (shape)
				6: begin
					w = 12'($urandom_range(0, 3));
					h = 12'($urandom_range(0, 3));
				end
				7: begin
					w = 12'($urandom_range(1, 12));
					h = 12'($urandom_range(301, 4095));
				end
				8: begin
					w = 12'($urandom_range(401, 4095));
					h = 12'($urandom_range(1, 300));
				end
				9: begin
					w = 12'($urandom_range(401, 4095));
					h = 12'($urandom_range(301, 4095));
				end
				default: begin
					w = 12'($urandom_range(1, 8));
					h = 12'($urandom_range(1, 6));
				end
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(gtdc_pkg::REG_SOURCE_WIDTH, w);
			if ($urandom_range(0, 3) != 0)
				write_reg(gtdc_pkg::REG_SOURCE_HEIGHT, h);
			if ($urandom_range(0, 1) != 0)
				write_reg(gtdc_pkg::REG_DEEP_MODE, 12'($urandom_range(0, 4095)));
			// some segments run flat out on one or both sides
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			seg_len = $urandom_range(8, 48);
			repeat (seg_len) send_pixel(8'($urandom_range(0, 255)));
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_unit_frames();
		test_extreme_size();
		test_scaled_frame_end();
		test_random_frames(RANDOM_PIXELS);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Sent %0d pixels and checked %0d texels (%0d row ends, %0d frame ends)",
		         pixels_sent, texels_checked, rows_closed, frames_closed);
		$display("Frames covered: reset size, 1x1, 4095x4095, decimated 401x301, random resizes");
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- gray_texel_decimating_converter.f -----
design/gtdc_pkg.sv
design/gray_texel_decimating_converter.sv
dv/tb_gray_texel_decimating_converter.sv
